[sv/gslp_pkg.sv]
// Shared types and constants for the gshare and loop branch predictor.
`default_nettype none

package gslp_pkg;

  // Two-bit saturating counter.
  typedef logic [1:0] ctr_t;

  localparam ctr_t STRONG_NOT_TAKEN = 2'd0;
  localparam ctr_t WEAK_TAKEN       = 2'd2;
  localparam ctr_t STRONG_TAKEN     = 2'd3;

  // Step a counter towards the resolved outcome, saturating at both ends.
  function automatic ctr_t ctr_step(input ctr_t c, input logic tkn);
    ctr_t r;
    r = c;
    if (tkn) begin
      if (c != STRONG_TAKEN) r = c + 2'd1;
    end else begin
      if (c != STRONG_NOT_TAKEN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/gslp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gslp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/gshare_loop_branch_predictor_unit.sv]
// Gshare two-bit predictor with a tagged loop predictor for backward branches.
// A beat passes the stage-1 and result registers. Throughput: one branch per
// cycle unless the result side stalls, set by the single read and write port
// of each table; a one-deep bypass covers back-to-back branches on one entry.
// Reset: history and loop valid bits clear at once; then a sweep sets every
// counter RAM entry to weakly taken, with in_ready held low.
`default_nettype none

module gshare_loop_branch_predictor_unit
  import gslp_pkg::*;
#(
  parameter int PATTERN_INDEX_BITS = 10,
  parameter int HISTORY_BITS       = 4,
  parameter int LOOP_INDEX_BITS    = 6,
  parameter int ITER_BITS          = 16,
  parameter int ADDR_BITS          = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // branch channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ADDR_BITS-1:0] pc,
  input  wire logic [ADDR_BITS-1:0] target,
  input  wire logic                 taken,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      predicted_taken,
  output logic                      prediction_correct,
  output logic                      is_backward,
  output logic                      from_loop_table
);

  localparam int PATTERN_DEPTH = 1 << PATTERN_INDEX_BITS;
  localparam int LOOP_DEPTH    = 1 << LOOP_INDEX_BITS;
  localparam int TAG_BITS      = ADDR_BITS - LOOP_INDEX_BITS;
  // loop entry layout in RAM: {tag, trip count, iteration}
  localparam int LOOP_WIDTH    = TAG_BITS + 2 * ITER_BITS;

  typedef logic [PATTERN_INDEX_BITS-1:0] pidx_t;
  typedef logic [LOOP_INDEX_BITS-1:0]    lidx_t;
  typedef logic [TAG_BITS-1:0]           tag_t;
  typedef logic [ITER_BITS-1:0]          iter_t;

  // ---------------------------------------------------------------------
  // Handshake and clearing sweep
  // ---------------------------------------------------------------------
  logic  clearing;
  pidx_t clr_addr;

  logic  in_fire;
  logic  s1_valid;
  logic  s1_adv;    // result register can take the stage-1 beat
  logic  s1_fire;

  assign s1_adv   = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_adv;
  // A new beat may enter when the sweep is done and stage 1 is empty or moving on this edge.
  assign in_ready = !clearing && (!s1_valid || s1_adv);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + pidx_t'(1);
      if (clr_addr == pidx_t'(PATTERN_DEPTH - 1)) clearing <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Global history: advanced as each beat is accepted, so the next beat's
  // index already sees this outcome.
  // ---------------------------------------------------------------------
  logic [HISTORY_BITS-1:0] hist;
  logic [HISTORY_BITS:0]   hist_shift;

  assign hist_shift = {hist, taken};

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (in_fire) begin
      hist <= hist_shift[HISTORY_BITS-1:0];
    end
  end

  pidx_t in_pidx;
  lidx_t in_lidx;

  assign in_pidx = pc[PATTERN_INDEX_BITS-1:0] ^ PATTERN_INDEX_BITS'(hist);
  assign in_lidx = pc[LOOP_INDEX_BITS-1:0];

  // ---------------------------------------------------------------------
  // Stage 1: input register, RAM read data arrives alongside
  // ---------------------------------------------------------------------
  logic [ADDR_BITS-1:0] s1_pc;
  logic [ADDR_BITS-1:0] s1_target;
  logic                 s1_taken;
  pidx_t                s1_pidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pc     <= pc;
      s1_target <= target;
      s1_taken  <= taken;
      s1_pidx   <= in_pidx;
    end
  end

  lidx_t s1_lidx;
  tag_t  s1_tag;
  logic  s1_backward;

  assign s1_lidx     = s1_pc[LOOP_INDEX_BITS-1:0];
  assign s1_tag      = s1_pc[ADDR_BITS-1:LOOP_INDEX_BITS];
  assign s1_backward = s1_target < s1_pc;

  // ---------------------------------------------------------------------
  // Pattern counter RAM. Written by the sweep, then by stage 1 as it
  // retires; read when a beat is accepted.
  // ---------------------------------------------------------------------
  ctr_t  ctr_rdata;
  ctr_t  ctr_cur;
  ctr_t  ctr_next;
  logic  ctr_we;
  pidx_t ctr_waddr;
  ctr_t  ctr_wdata;

  assign ctr_we    = clearing || s1_fire;
  assign ctr_waddr = clearing ? clr_addr : s1_pidx;
  assign ctr_wdata = clearing ? WEAK_TAKEN : ctr_next;

  gslp_ram #(
    .WIDTH ($bits(ctr_t)),
    .DEPTH (PATTERN_DEPTH)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .re    (in_fire),
    .raddr (in_pidx),
    .rdata (ctr_rdata)
  );

  // Bypass: the beat ahead writes its entry on the same edge this one reads.
  logic ctr_byp_hit;
  ctr_t ctr_byp;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctr_byp_hit <= s1_fire && (s1_pidx == in_pidx);
      ctr_byp     <= ctr_next;
    end
  end

  assign ctr_cur  = ctr_byp_hit ? ctr_byp : ctr_rdata;
  assign ctr_next = ctr_step(ctr_cur, s1_taken);

  // ---------------------------------------------------------------------
  // Loop table: present and trained bits in flops, tag and counts in RAM.
  // A tag or count is only trusted once the entry is present.
  // ---------------------------------------------------------------------
  logic [LOOP_DEPTH-1:0] loop_present;
  logic [LOOP_DEPTH-1:0] loop_trained;

  logic [LOOP_WIDTH-1:0] loop_rdata;
  logic [LOOP_WIDTH-1:0] loop_cur;
  logic [LOOP_WIDTH-1:0] loop_wdata;
  logic                  loop_we;

  assign loop_we = s1_fire && s1_backward;

  gslp_ram #(
    .WIDTH (LOOP_WIDTH),
    .DEPTH (LOOP_DEPTH)
  ) u_loop_ram (
    .clk   (clk),
    .we    (loop_we),
    .waddr (s1_lidx),
    .wdata (loop_wdata),
    .re    (in_fire),
    .raddr (in_lidx),
    .rdata (loop_rdata)
  );

  logic                  loop_byp_hit;
  logic [LOOP_WIDTH-1:0] loop_byp;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      loop_byp_hit <= loop_we && (s1_lidx == in_lidx);
      loop_byp     <= loop_wdata;
    end
  end

  assign loop_cur = loop_byp_hit ? loop_byp : loop_rdata;

  tag_t  ent_tag;
  iter_t ent_trip;
  iter_t ent_iter;
  logic  ent_hit;
  logic  eff_trained;
  iter_t eff_trip;
  iter_t eff_iter;
  iter_t trip_next;
  iter_t iter_next;
  logic  trained_next;

  assign ent_tag  = loop_cur[LOOP_WIDTH-1 -: TAG_BITS];
  assign ent_trip = loop_cur[2*ITER_BITS-1 -: ITER_BITS];
  assign ent_iter = loop_cur[ITER_BITS-1:0];
  assign ent_hit  = loop_present[s1_lidx] && (ent_tag == s1_tag);

  // On a miss the entry is reallocated: untrained, counts at zero.
  assign eff_trained = ent_hit && loop_trained[s1_lidx];
  assign eff_trip    = ent_hit ? ent_trip : '0;
  assign eff_iter    = ent_hit ? ent_iter : '0;

  always_comb begin
    if (s1_taken) begin
      trip_next    = eff_trip;
      iter_next    = (eff_iter == '1) ? eff_iter : eff_iter + iter_t'(1);
      trained_next = eff_trained;
    end else begin
      // loop exit: learn the trip count
      trip_next    = eff_iter;
      iter_next    = '0;
      trained_next = 1'b1;
    end
  end

  assign loop_wdata = {s1_tag, trip_next, iter_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_present <= '0;
      loop_trained <= '0;
    end else if (loop_we) begin
      loop_present[s1_lidx] <= 1'b1;
      loop_trained[s1_lidx] <= trained_next;
    end
  end

  // ---------------------------------------------------------------------
  // Prediction and result register
  // ---------------------------------------------------------------------
  logic s1_from_loop;
  logic s1_pred;

  assign s1_from_loop = s1_backward && eff_trained;
  assign s1_pred      = s1_from_loop ? (eff_iter != eff_trip) : ctr_cur[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      predicted_taken    <= s1_pred;
      prediction_correct <= (s1_pred == s1_taken);
      is_backward        <= s1_backward;
      from_loop_table    <= s1_from_loop;
    end
  end

`ifndef SYNTHESIS
  // No branch enters while the counter sweep is running.
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("branch accepted during counter sweep");

  // An accepted beat is in stage 1 on the next cycle.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted beat lost before stage 1");

  // A stalled stage-1 beat is not dropped.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("stage-1 beat dropped under stall");

  // The loop table only ever predicts backward branches.
  a_loop_only_backward: assert property (@(posedge clk) disable iff (rst)
    (out_valid && from_loop_table) |-> is_backward)
    else $error("loop prediction on a forward branch");

  // A loop table write marks its entry present.
  a_trained_implies_present: assert property (@(posedge clk) disable iff (rst)
    loop_we |=> loop_present[$past(s1_lidx)])
    else $error("loop entry written but not marked present");
`endif

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the gshare and loop branch predictor unit.
`timescale 1ns / 1ps

module tb_top
  import gslp_pkg::*;
();

  // Block geometry, kept at the unit's defaults.
  localparam int PIDX_W     = 10;
  localparam int HIST_W     = 4;
  localparam int LIDX_W     = 6;
  localparam int ITER_W     = 16;
  localparam int ADDR_W     = 48;
  localparam int TAG_W      = ADDR_W - LIDX_W;
  localparam int PHT_DEPTH  = 1 << PIDX_W;
  localparam int LOOP_DEPTH = 1 << LIDX_W;

  localparam int IDLE_PCT       = 13;      // per-cycle idle chance on each side
  localparam int RANDOM_BEATS   = 780;
  localparam int POOL_SIZE      = 6;
  localparam int WATCHDOG_LIMIT = 100000;  // cycles

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ITER_W-1:0] iter_t;

  localparam addr_t ADDR_MAX = {ADDR_W{1'b1}};
  localparam iter_t ITER_MAX = {ITER_W{1'b1}};

  // One result beat, field order as on the ports.
  typedef struct packed {
    logic predicted_taken;
    logic prediction_correct;
    logic is_backward;
    logic from_loop_table;
  } outcome_t;

  // One directed branch; 'typed' marks a row whose outcome is written in by hand.
  typedef struct packed {
    addr_t    pc;
    addr_t    target;
    logic     taken;
    logic     typed;
    outcome_t want;
  } branch_row_t;

  localparam outcome_t NO_CHECK = '0;

  // A short backward loop, and a second branch aliasing its loop-table slot.
  localparam addr_t LOOP_PC   = 48'h0000_1000_0040;
  localparam addr_t LOOP_TGT  = 48'h0000_1000_0000;
  localparam addr_t ALIAS_PC  = 48'h0000_2000_0040;

  localparam int N_DIRECTED = 20;
  localparam branch_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // fresh counters are weakly taken: forward taken branch is right
    '{48'h0, 48'h0, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0}},
    // highest pc, backward: slot allocated, untrained, counter says taken
    '{ADDR_MAX, 48'h0, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0}},
    // same slot now trained with trip 0: loop table says not taken
    '{ADDR_MAX, 48'h0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1}},
    '{48'h0, ADDR_MAX, 1'b0, 1'b0, NO_CHECK},
    '{ADDR_MAX, ADDR_MAX, 1'b1, 1'b0, NO_CHECK},   // equal addresses: forward
    // three trips round the loop, exit, then a trained second pass
    '{LOOP_PC, LOOP_TGT, 1'b1, 1'b0, NO_CHECK},
    '{LOOP_PC, LOOP_TGT, 1'b1, 1'b0, NO_CHECK},
    '{LOOP_PC, LOOP_TGT, 1'b1, 1'b0, NO_CHECK},
    '{LOOP_PC, LOOP_TGT, 1'b0, 1'b0, NO_CHECK},
    '{LOOP_PC, LOOP_TGT, 1'b1, 1'b0, NO_CHECK},
    '{LOOP_PC, LOOP_TGT, 1'b1, 1'b0, NO_CHECK},
    '{LOOP_PC, LOOP_TGT, 1'b1, 1'b0, NO_CHECK},
    '{LOOP_PC, LOOP_TGT, 1'b0, 1'b0, NO_CHECK},
    // tag miss both ways on the shared slot
    '{ALIAS_PC, LOOP_TGT, 1'b1, 1'b0, NO_CHECK},
    '{LOOP_PC, LOOP_TGT, 1'b1, 1'b0, NO_CHECK},
    '{48'h1, 48'h0, 1'b1, 1'b0, NO_CHECK},
    '{48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 1'b0, 1'b0, NO_CHECK},
    '{48'haaaa_aaaa_aaaa, 48'h5555_5555_5555, 1'b1, 1'b0, NO_CHECK},
    '{LOOP_PC, LOOP_TGT, 1'b0, 1'b0, NO_CHECK},
    '{LOOP_PC, LOOP_TGT, 1'b0, 1'b0, NO_CHECK}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset and the unit's pins. Every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  addr_t pc        = '0;
  addr_t target    = '0;
  logic  taken     = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  logic  predicted_taken;
  logic  prediction_correct;
  logic  is_backward;
  logic  from_loop_table;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gshare_loop_branch_predictor_unit #(
    .PATTERN_INDEX_BITS (PIDX_W),
    .HISTORY_BITS       (HIST_W),
    .LOOP_INDEX_BITS    (LIDX_W),
    .ITER_BITS          (ITER_W),
    .ADDR_BITS          (ADDR_W)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .pc                 (pc),
    .target             (target),
    .taken              (taken),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .predicted_taken    (predicted_taken),
    .prediction_correct (prediction_correct),
    .is_backward        (is_backward),
    .from_loop_table    (from_loop_table)
  );

  // ---------------------------------------------------------------------------
  // Predictor mirror: history, counter table and loop table, updated once per
  // accepted branch beat in acceptance order.
  // ---------------------------------------------------------------------------
  logic [HIST_W-1:0] ghist;
  ctr_t              pht        [PHT_DEPTH];
  logic              lp_valid   [LOOP_DEPTH];
  logic [TAG_W-1:0]  lp_tag     [LOOP_DEPTH];
  logic              lp_trained [LOOP_DEPTH];
  iter_t             lp_trip    [LOOP_DEPTH];
  iter_t             lp_iter    [LOOP_DEPTH];

  outcome_t expected_outcomes [$];

  int unsigned errors       = 0;
  int unsigned beats_sent   = 0;
  int unsigned beats_seen   = 0;
  int unsigned backward_cnt = 0;
  int unsigned loop_cnt     = 0;
  int unsigned mispredicts  = 0;
  int unsigned cycles       = 0;
  bit          steady       = 1'b0; // no idling on either side while set

  // Works out the result of one branch and advances the mirrored state.
  function automatic outcome_t resolve_branch(input addr_t bpc, input addr_t btgt,
                                              input logic btk);
    outcome_t          o;
    logic [PIDX_W-1:0] pidx;
    logic [LIDX_W-1:0] li;
    logic [TAG_W-1:0]  tag;
    ctr_t              cnt;
    pidx = bpc[PIDX_W-1:0] ^ PIDX_W'(ghist);
    cnt  = pht[pidx];
    o.predicted_taken = (cnt >= WEAK_TAKEN);
    o.is_backward     = (btgt < bpc);
    o.from_loop_table = 1'b0;
    if (o.is_backward) begin
      li  = bpc[LIDX_W-1:0];
      tag = bpc[ADDR_W-1:LIDX_W];
      // tag miss or empty slot: reallocate before predicting
      if (!lp_valid[li] || lp_tag[li] != tag) begin
        lp_valid[li]   = 1'b1;
        lp_tag[li]     = tag;
        lp_trained[li] = 1'b0;
        lp_trip[li]    = '0;
        lp_iter[li]    = '0;
      end
      if (lp_trained[li]) begin
        o.from_loop_table = 1'b1;
        o.predicted_taken = (lp_iter[li] != lp_trip[li]);
      end
      if (btk) begin
        if (lp_iter[li] != ITER_MAX) lp_iter[li] = lp_iter[li] + iter_t'(1);
      end else begin
        // loop exit: learn the trip count
        lp_trip[li]    = lp_iter[li];
        lp_iter[li]    = '0;
        lp_trained[li] = 1'b1;
      end
    end
    if (btk) begin
      if (cnt != STRONG_TAKEN) cnt = cnt + 2'd1;
    end else begin
      if (cnt != STRONG_NOT_TAKEN) cnt = cnt - 2'd1;
    end
    pht[pidx] = cnt;
    ghist = {ghist[HIST_W-2:0], btk};
    o.prediction_correct = (o.predicted_taken == btk);
    return o;
  endfunction

  // Presents one branch beat, idling beforehand at random, and files the
  // expected outcome once the beat is taken.
  task automatic send_branch(input addr_t bpc, input addr_t btgt, input logic btk,
                             input logic typed = 1'b0, input outcome_t want = '0);
    outcome_t mirrored;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pc       <= bpc;
    target   <= btgt;
    taken    <= btk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirrored = resolve_branch(bpc, btgt, btk);
    expected_outcomes.push_back(typed ? want : mirrored);
    beats_sent++;
  endtask

  // Holds the branch channel quiet until every result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, then an in-order field-by-field check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    outcome_t exp_o;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      if (is_backward === 1'b1) backward_cnt++;
      if (from_loop_table === 1'b1) loop_cnt++;
      if (prediction_correct === 1'b0) mispredicts++;
      if (expected_outcomes.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_o = expected_outcomes.pop_front();
        if (predicted_taken !== exp_o.predicted_taken) begin
          $error("predicted_taken: expected %0b, got %0b",
                 exp_o.predicted_taken, predicted_taken);
          errors++;
        end
        if (prediction_correct !== exp_o.prediction_correct) begin
          $error("prediction_correct: expected %0b, got %0b",
                 exp_o.prediction_correct, prediction_correct);
          errors++;
        end
        if (is_backward !== exp_o.is_backward) begin
          $error("is_backward: expected %0b, got %0b", exp_o.is_backward, is_backward);
          errors++;
        end
        if (from_loop_table !== exp_o.from_loop_table) begin
          $error("from_loop_table: expected %0b, got %0b",
                 exp_o.from_loop_table, from_loop_table);
          errors++;
        end
      end
    end
  end

  // Watchdog: covers a hung handshake anywhere, including the final drain.
  initial begin
    wait (cycles >= WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    addr_t       pool_pc  [POOL_SIZE];
    addr_t       pool_tgt [POOL_SIZE];
    int unsigned random_start;
    int unsigned k;
    int unsigned trip;
    int unsigned passes;
    addr_t       npc;

    // Mirror starts from the reset state; entries never read before allocation.
    ghist = '0;
    for (int i = 0; i < PHT_DEPTH; i++) pht[i] = WEAK_TAKEN;
    for (int i = 0; i < LOOP_DEPTH; i++) begin
      lp_valid[i]   = 1'b0;
      lp_tag[i]     = '0;
      lp_trained[i] = 1'b0;
      lp_trip[i]    = '0;
      lp_iter[i]    = '0;
    end

    // Loop branches for the random part; one pair shares a loop-table slot
    // with different tags so that reallocation keeps happening.
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_pc[i] = addr_t'({$urandom(), $urandom()}) | addr_t'(48'h1_0000);
    end
    pool_pc[3] = {~pool_pc[0][ADDR_W-1:LIDX_W], pool_pc[0][LIDX_W-1:0]}
                 | addr_t'(48'h1_0000);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_tgt[i] = pool_pc[i] - addr_t'($urandom_range(1, 65535));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; in_ready stays low through the counter sweep after reset.
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_branch(DIRECTED_ROWS[r].pc, DIRECTED_ROWS[r].target, DIRECTED_ROWS[r].taken,
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end
    drain_results();

    // Random part: mostly whole loops (taken body beats then an exit), some
    // with early exits or stray forward branches, the rest pure noise.
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      steady = (beats_sent - random_start >= 300) && (beats_sent - random_start < 450);
      if (beats_sent - random_start >= 500 && beats_sent - random_start < 505) begin
        drain_results();
      end
      if ($urandom_range(0, 99) < 70) begin
        k      = $urandom_range(0, POOL_SIZE - 1);
        trip   = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        passes = $urandom_range(1, 4);
        for (int p = 0; p < passes; p++) begin
          // broken pass: exit early or late
          if ($urandom_range(0, 4) == 0) trip = $urandom_range(0, 12);
          for (int i = 0; i < trip; i++) begin
            if ($urandom_range(0, 19) == 0) begin
              npc = addr_t'({$urandom(), $urandom()});
              send_branch(npc, npc + addr_t'($urandom_range(0, 4096)),
                          1'($urandom_range(0, 1)));
            end
            send_branch(pool_pc[k], pool_tgt[k], 1'b1);
          end
          send_branch(pool_pc[k], pool_tgt[k], 1'b0);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_branch(addr_t'({$urandom(), $urandom()}), addr_t'({$urandom(), $urandom()}),
                      1'($urandom_range(0, 1)));
        end
      end
    end
    steady = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);

    $display("Run covered %0d branch beats and %0d results (%0d backward, %0d from loop",
             beats_sent, beats_seen, backward_cnt, loop_cnt);
    $display("  table, %0d mispredicted), with slot aliasing, loop exits and stalls.",
             mispredicts);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
